>>> rtl/nkm_pkg.sv
// shared constants and types for the nearest key match set
`timescale 1ns / 1ps

package nkm_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 31;

    localparam int TOTAL_W = 20;
    localparam logic [TOTAL_W:0] TOTAL_MOD = 21'd1000000;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
        logic rem_pred;
    } cell_ctrl_t;

endpackage

>>> rtl/nkm_cell.sv
// one cell of the sorted key chain
`timescale 1ns / 1ps

module nkm_cell #(
    parameter int KEY_BITS = nkm_pkg::DEF_KEY_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nkm_pkg::cell_ctrl_t ctrl,
    input  logic [KEY_BITS-1:0] item_key,
    input  logic                flag_left,
    input  logic                flag_right,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_valid,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic                right_valid,
    output logic [KEY_BITS-1:0] key_o,
    output logic                valid_o,
    output logic                flag_o,
    output logic                is_pred,
    output logic                is_succ
);
    import nkm_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                valid_reg, valid_next;
    logic                flag_reg, flag_next;
    logic                shift_out;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        flag_next  = flag_reg;
        shift_out  = ctrl.rem_pred ? !flag_right : !flag_reg;
        if (ctrl.cmp) begin
            flag_next = valid_reg && (key_reg <= item_key);
        end
        if (ctrl.ins && !flag_reg) begin
            if (flag_left) begin
                key_next   = item_key;
                valid_next = 1'b1;
            end else begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end else if (ctrl.rem && shift_out) begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_o   = key_reg;
    assign valid_o = valid_reg;
    assign flag_o  = flag_reg;
    assign is_pred = flag_reg && !flag_right;
    assign is_succ = valid_reg && !flag_reg && flag_left;

endmodule

>>> rtl/nkm_mod.sv
// reduction of a cost modulo one million by folding the bits above bit 19
`timescale 1ns / 1ps

module nkm_mod #(
    parameter int KEY_BITS = nkm_pkg::DEF_KEY_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [KEY_BITS-1:0]         din,
    output logic                        done,
    output logic [nkm_pkg::TOTAL_W-1:0] rem
);
    import nkm_pkg::*;

    localparam int XW     = (KEY_BITS > TOTAL_W) ? KEY_BITS : TOTAL_W + 1;
    localparam int HI_W   = XW - TOTAL_W;
    localparam int FOLD_W = 16;
    localparam int FOLD_I = (1 << TOTAL_W) - int'(TOTAL_MOD);
    localparam logic [FOLD_W-1:0] FOLD_C = FOLD_W'(FOLD_I);

    logic [XW-1:0]          x_reg, x_next;
    logic [TOTAL_W-1:0]     r_reg, r_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [HI_W-1:0]        hi;
    logic [HI_W+FOLD_W-1:0] prod;
    logic [TOTAL_W:0]       t;
    logic [TOTAL_W:0]       t_sub;

    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        hi        = x_reg[XW-1:TOTAL_W];
        prod      = hi * FOLD_C;
        t         = x_reg[TOTAL_W:0];
        t_sub     = t - TOTAL_MOD;
        if (start) begin
            x_next    = XW'(din);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (hi != '0) begin
                // 2^20 is 48576 modulo one million
                x_next = XW'(prod) + XW'(x_reg[TOTAL_W-1:0]);
            end else begin
                r_next    = (t >= TOTAL_MOD) ? t_sub[TOTAL_W-1:0] : t[TOTAL_W-1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

>>> rtl/nearest_key_match_set.sv
// top level of the nearest key match set
`timescale 1ns / 1ps
//
// keeps a sorted multiset of waiting keys of one kind in a chain of cells
// input item: s_tuser = kind, s_tdata = key; one result item per input item
// result item: m_tuser = {dropped, matched}, m_tdata = {total, cost, matched_key}
// an item of the pool kind, or any item while the set is empty, is inserted
// in sorted place by a shift of the chain; a full chain drops it
// an item of the other kind removes the nearest stored key (smaller on a tie)
// insert: the item passes the states CMP, SEL and OUT before its result
// is registered; match: the item passes CMP, SEL, DIFF, PICK, MOD, ADD and
// OUT, and MOD waits for the reduction of the cost modulo one million,
// one fold per cycle while the cost has bits above bit 19
// one item is in work at a time; s_tready is high only when the block is idle
// the result sits in an output register until m_tready takes it, while the
// next item may already be accepted and worked up to its result
// reset empties the chain and clears pool kind, count and running total
//
module nearest_key_match_set #(
    parameter int CAPACITY = nkm_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = nkm_pkg::DEF_KEY_BITS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // key
    input  logic [((KEY_BITS+7)/8)*8-1:0]                 s_tdata,
    // kind
    input  logic [0:0]                                    s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // matched_key, cost, total
    output logic [((2*KEY_BITS+nkm_pkg::TOTAL_W+7)/8)*8-1:0] m_tdata,
    // matched, dropped
    output logic [1:0]                                    m_tuser
);
    import nkm_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int OUT_W  = ((2*KEY_BITS+TOTAL_W+7)/8)*8;
    localparam int PAD_W  = OUT_W - 2*KEY_BITS - TOTAL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_PICK = 3'd4;
    localparam logic [2:0] ST_MOD  = 3'd5;
    localparam logic [2:0] ST_ADD  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic                pool_kind_reg, pool_kind_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                op_ins_reg, op_ins_next;
    logic [KEY_BITS-1:0] item_key_reg, item_key_next;
    logic [KEY_BITS-1:0] pred_key_reg, pred_key_next;
    logic [KEY_BITS-1:0] succ_key_reg, succ_key_next;
    logic                has_pred_reg, has_pred_next;
    logic                has_succ_reg, has_succ_next;
    logic [KEY_BITS-1:0] dlo_reg, dlo_next;
    logic [KEY_BITS-1:0] dhi_reg, dhi_next;
    logic                res_matched_reg, res_matched_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic [KEY_BITS-1:0] res_cost_reg, res_cost_next;
    logic                res_drop_reg, res_drop_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    cell_ctrl_t          ctrl;
    logic                mod_start;
    logic                mod_done;
    logic [TOTAL_W-1:0]  mod_rem;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W:0]    sum_sub;
    logic                use_pred;
    logic                in_fire;
    logic                out_free;

    logic [KEY_BITS-1:0] cell_key   [CAPACITY];
    logic                cell_valid [CAPACITY];
    logic                cell_flag  [CAPACITY];
    logic [CAPACITY-1:0] pred_vec;
    logic [CAPACITY-1:0] succ_vec;
    logic [KEY_BITS-1:0] pred_gather;
    logic [KEY_BITS-1:0] succ_gather;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                fl_left;
            logic                fl_right;
            logic [KEY_BITS-1:0] k_left;
            logic                v_left;
            logic [KEY_BITS-1:0] k_right;
            logic                v_right;
            if (gi == 0) begin : g_first
                assign fl_left = 1'b1;
                assign k_left  = '0;
                assign v_left  = 1'b0;
            end else begin : g_mid_l
                assign fl_left = cell_flag[gi-1];
                assign k_left  = cell_key[gi-1];
                assign v_left  = cell_valid[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign fl_right = 1'b0;
                assign k_right  = '0;
                assign v_right  = 1'b0;
            end else begin : g_mid_r
                assign fl_right = cell_flag[gi+1];
                assign k_right  = cell_key[gi+1];
                assign v_right  = cell_valid[gi+1];
            end
            nkm_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .item_key    (item_key_reg),
                .flag_left   (fl_left),
                .flag_right  (fl_right),
                .left_key    (k_left),
                .left_valid  (v_left),
                .right_key   (k_right),
                .right_valid (v_right),
                .key_o       (cell_key[gi]),
                .valid_o     (cell_valid[gi]),
                .flag_o      (cell_flag[gi]),
                .is_pred     (pred_vec[gi]),
                .is_succ     (succ_vec[gi])
            );
        end
    endgenerate

    nkm_mod #(
        .KEY_BITS(KEY_BITS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .din     (res_cost_next),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // one-hot gather of the neighbors around the item key
    always_comb begin
        pred_gather = '0;
        succ_gather = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pred_gather = pred_gather | (cell_key[i] & {KEY_BITS{pred_vec[i]}});
            succ_gather = succ_gather | (cell_key[i] & {KEY_BITS{succ_vec[i]}});
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign use_pred = has_pred_reg && (!has_succ_reg || (dlo_reg <= dhi_reg));
    assign sum      = {1'b0, total_reg} + {1'b0, mod_rem};
    assign sum_sub  = sum - TOTAL_MOD;

    always_comb begin
        state_next       = state_reg;
        pool_kind_next   = pool_kind_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        op_ins_next      = op_ins_reg;
        item_key_next    = item_key_reg;
        pred_key_next    = pred_key_reg;
        succ_key_next    = succ_key_reg;
        has_pred_next    = has_pred_reg;
        has_succ_next    = has_succ_reg;
        dlo_next         = dlo_reg;
        dhi_next         = dhi_reg;
        res_matched_next = res_matched_reg;
        res_key_next     = res_key_reg;
        res_cost_next    = res_cost_reg;
        res_drop_next    = res_drop_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ctrl             = '0;
        mod_start        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    item_key_next = s_tdata[KEY_BITS-1:0];
                    if (count_reg == '0) begin
                        pool_kind_next = s_tuser[0];
                        op_ins_next    = 1'b1;
                    end else begin
                        op_ins_next = (s_tuser[0] == pool_kind_reg);
                    end
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctrl.cmp   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                if (op_ins_reg) begin
                    res_matched_next = 1'b0;
                    res_key_next     = '0;
                    res_cost_next    = '0;
                    if (count_reg == CNT_W'(CAPACITY)) begin
                        res_drop_next = 1'b1;
                    end else begin
                        res_drop_next = 1'b0;
                        ctrl.ins      = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end else begin
                    pred_key_next = pred_gather;
                    succ_key_next = succ_gather;
                    has_pred_next = |pred_vec;
                    has_succ_next = |succ_vec;
                    state_next    = ST_DIFF;
                end
            end
            ST_DIFF: begin
                dlo_next   = item_key_reg - pred_key_reg;
                dhi_next   = succ_key_reg - item_key_reg;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                ctrl.rem         = 1'b1;
                ctrl.rem_pred    = use_pred;
                count_next       = count_reg - 1'b1;
                res_matched_next = 1'b1;
                res_drop_next    = 1'b0;
                res_key_next     = use_pred ? pred_key_reg : succ_key_reg;
                res_cost_next    = use_pred ? dlo_reg : dhi_reg;
                mod_start        = 1'b1;
                state_next       = ST_MOD;
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                total_next = (sum >= TOTAL_MOD) ? sum_sub[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, total_reg, res_cost_reg, res_key_reg};
                    m_tuser_next  = {res_drop_reg, res_matched_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pool_kind_reg <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pool_kind_reg <= pool_kind_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_ins_reg      <= op_ins_next;
        item_key_reg    <= item_key_next;
        pred_key_reg    <= pred_key_next;
        succ_key_reg    <= succ_key_next;
        has_pred_reg    <= has_pred_next;
        has_succ_reg    <= has_succ_next;
        dlo_reg         <= dlo_next;
        dhi_reg         <= dhi_next;
        res_matched_reg <= res_matched_next;
        res_key_reg     <= res_key_next;
        res_cost_reg    <= res_cost_next;
        res_drop_reg    <= res_drop_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/nkm_checker.sv
// port checks for the nearest key match set and their binding
`timescale 1ns / 1ps

module nkm_checker #(
    parameter int KEY_BITS = nkm_pkg::DEF_KEY_BITS
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          s_tvalid,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((2*KEY_BITS+nkm_pkg::TOTAL_W+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                                    m_tuser
);
    import nkm_pkg::*;

    localparam int TOT_LO = 2*KEY_BITS;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("matched and dropped both set");

    // unmatched result carries zero key and cost
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[TOT_LO-1:0] == '0)
        else $error("unmatched item with nonzero key or cost");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {1'b0, m_tdata[TOT_LO+TOTAL_W-1:TOT_LO]} < TOTAL_MOD)
        else $error("total out of range");

endmodule

bind nearest_key_match_set nkm_checker #(
    .KEY_BITS(KEY_BITS)
) u_nkm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
